>>> hw/rtl/kve_pkg.sv
// kve_pkg: shared types, constants and helpers for the keyed value extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kve_pkg;

  // Default longest key the history register is sized for.
  localparam int KEY_MAX_DEF = 16;

  // Result queue depth; must leave room for the two results one byte can cause.
  localparam int RQ_DEPTH = 4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BAR = 8'h7C;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_KEY_LOW    = 3'd0;
  localparam cfg_index_t REG_KEY_HIGH   = 3'd1;
  localparam cfg_index_t REG_KEY_LENGTH = 3'd2;
  localparam cfg_index_t REG_OCCURRENCE = 3'd3;
  localparam cfg_index_t REG_PICKY_MODE = 3'd4;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_FIRST,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic       has_char;
    logic       last;
    logic       found;
  } result_beat_t;

  typedef struct packed {
    cfg_index_t  index;
    logic [63:0] wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic [63:0] key_chars_low;
    logic [63:0] key_chars_high;
    logic [4:0]  key_length;
    logic [7:0]  occurrence;
    logic        picky_mode;
  } kve_cfg_t;

  // Results written into the queue in one cycle (0, 1 or 2 of them).
  typedef struct packed {
    logic [1:0]   count;
    result_beat_t first;
    result_beat_t second;
  } kve_push_t;

  localparam result_beat_t FAIL_BEAT = '{value_char: 8'h00, has_char: 1'b0,
                                         last: 1'b1, found: 1'b0};

  // Key character i; characters past the sixteenth read as zero.
  function automatic logic [7:0] key_char(logic [63:0] lo, logic [63:0] hi,
                                          logic [5:0] i);
    logic [63:0] word;
    word = (i[3] == 1'b0) ? lo : hi;
    if (i >= 6'd16) begin
      return 8'h00;
    end
    return 8'(word >> {i[2:0], 3'b000});
  endfunction

  function automatic logic is_line_end(logic [7:0] c);
    return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

>>> hw/rtl/kve_stream_if.sv
// kve_stream_if: valid/ready channel carrying one payload beat of type T.
// No dependencies; payload types come from kve_pkg at the instance.
`timescale 1ns / 1ps

interface kve_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/kve_cfg_regs.sv
// kve_cfg_regs: configuration register file written over the cfg channel.
// Depends on kve_pkg and kve_stream_if.
`timescale 1ns / 1ps

module kve_cfg_regs import kve_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  kve_stream_if.sink cfg,
  output kve_cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key_chars_low  <= '0;
      regs.key_chars_high <= '0;
      regs.key_length     <= '0;
      regs.occurrence     <= 8'd1;
      regs.picky_mode     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_KEY_LOW:    regs.key_chars_low  <= cfg.data.wdata;
        REG_KEY_HIGH:   regs.key_chars_high <= cfg.data.wdata;
        REG_KEY_LENGTH: regs.key_length     <= cfg.data.wdata[4:0];
        REG_OCCURRENCE: regs.occurrence     <= cfg.data.wdata[7:0];
        REG_PICKY_MODE: regs.picky_mode     <= cfg.data.wdata[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/kve_core.sv
// kve_core: input register, key history, match counter and value phase control.
// Depends on kve_pkg and kve_stream_if; pushes results into kve_result_queue.
`timescale 1ns / 1ps

module kve_core import kve_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kve_stream_if.sink text,
  input  kve_cfg_t  regs,
  input  logic      room,
  output kve_push_t push
);

  localparam int HIST_LEN = KEY_MAX + 1;
  localparam int SW       = $clog2(HIST_LEN + 1);

  // input register
  logic       in_v;
  text_beat_t in_beat;
  logic       advance;

  assign advance    = in_v && room;
  assign text.ready = !in_v || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_beat <= text.data;
    end
  end

  // state
  logic [7:0]    hist [HIST_LEN];
  logic [7:0]    hist_next [HIST_LEN];
  logic [SW-1:0] seen, seen_next;
  logic [SW-1:0] seen_inc;
  logic [7:0]    match_count, match_count_next;
  logic [7:0]    held_char, held_char_next;
  phase_t        phase, phase_next;

  logic [7:0] c;
  logic       eot;
  logic       key_ok;
  logic       hit_occ;
  logic       picky_bad;
  logic       take;
  logic [7:0] cnt_inc;
  logic [7:0] prev_char;
  logic       shift_en;

  assign c   = in_beat.text_char;
  assign eot = in_beat.end_of_text;

  // history as it stands after this byte goes in, newest at index 0
  always_comb begin
    hist_next[0] = c;
    for (int j = 1; j < HIST_LEN; j++) begin
      hist_next[j] = hist[j-1];
    end
  end

  assign seen_inc = (32'(seen) < HIST_LEN) ? seen + SW'(1) : seen;
  assign cnt_inc  = (match_count != 8'hFF) ? match_count + 8'd1 : 8'hFF;

  // parallel key compare across the history lanes
  always_comb begin
    key_ok = (regs.key_length != 5'd0) && (32'(regs.key_length) <= KEY_MAX) &&
             (32'(seen_inc) >= 32'(regs.key_length));
    for (int j = 0; j < KEY_MAX; j++) begin
      if (32'(regs.key_length) > j) begin
        if (hist_next[j] != key_char(regs.key_chars_low, regs.key_chars_high,
                                     6'(regs.key_length) - 6'(j) - 6'd1)) begin
          key_ok = 1'b0;
        end
      end
    end
  end

  // byte just before the candidate
  always_comb begin
    prev_char = 8'h00;
    for (int j = 0; j < HIST_LEN; j++) begin
      if (32'(regs.key_length) == j) begin
        prev_char = hist_next[j];
      end
    end
  end

  assign hit_occ   = (cnt_inc == regs.occurrence);
  assign picky_bad = hit_occ && regs.picky_mode &&
                     (32'(seen_inc) > 32'(regs.key_length)) &&
                     !((prev_char == CH_LF) || (prev_char == CH_CR) ||
                       (prev_char == CH_BAR));
  assign take      = key_ok && !picky_bad;
  assign shift_en  = advance && (phase == PH_SEARCH) && (c != CH_NUL);

  // next state
  always_comb begin
    phase_next       = phase;
    seen_next        = seen;
    match_count_next = match_count;
    held_char_next   = held_char;
    unique case (phase)
      PH_SEARCH: begin
        if (c == CH_NUL) begin
          phase_next = PH_DONE;
        end else begin
          seen_next = seen_inc;
          if (take) begin
            match_count_next = cnt_inc;
            if (hit_occ) begin
              phase_next = PH_FIRST;
            end
          end
        end
      end
      PH_FIRST: begin
        if (is_line_end(c)) begin
          phase_next = PH_DONE;
        end else if (!eot) begin
          held_char_next = c;
          phase_next     = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_line_end(c)) begin
          phase_next = PH_DONE;
        end else begin
          held_char_next = c;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
    if (eot) begin
      phase_next       = PH_SEARCH;
      seen_next        = '0;
      match_count_next = '0;
    end
  end

  // results
  always_comb begin
    push.count  = 2'd0;
    push.first  = FAIL_BEAT;
    push.second = '{value_char: c, has_char: 1'b1, last: 1'b1, found: 1'b1};
    unique case (phase)
      PH_SEARCH: begin
        if ((c == CH_NUL) || eot) begin
          push.count = 2'd1;
        end
      end
      PH_FIRST: begin
        if (is_line_end(c)) begin
          push.count = 2'd1;
        end else if (eot) begin
          push.count = 2'd1;
          push.first = '{value_char: c, has_char: 1'b1, last: 1'b1, found: 1'b1};
        end
      end
      PH_VALUE: begin
        push.first = '{value_char: held_char, has_char: 1'b1, last: 1'b0,
                       found: 1'b1};
        if (is_line_end(c)) begin
          push.count      = 2'd1;
          push.first.last = 1'b1;
        end else if (eot) begin
          push.count = 2'd2;
        end else begin
          push.count = 2'd1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      seen        <= '0;
      match_count <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      seen        <= seen_next;
      match_count <= match_count_next;
    end
  end

  // history is only read below the fill count, so it needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      held_char <= held_char_next;
    end
    if (shift_en) begin
      for (int j = 0; j < HIST_LEN; j++) begin
        hist[j] <= hist_next[j];
      end
    end
  end

endmodule

>>> hw/rtl/kve_result_queue.sv
// kve_result_queue: small result queue taking up to two beats per cycle.
// Depends on kve_pkg and kve_stream_if; drives the result channel.
`timescale 1ns / 1ps

module kve_result_queue import kve_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  kve_push_t push,
  output logic      room,
  kve_stream_if.source result
);

  localparam int PW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  result_beat_t  q [RQ_DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          pop;

  assign room         = 32'(count) <= RQ_DEPTH - 2;
  assign result.valid = count != '0;
  assign result.data  = q[head];
  assign pop          = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PW'(pop);
      tail  <= tail + PW'(push.count);
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[tail + PW'(1)] <= push.second;
    end
  end

endmodule

>>> hw/rtl/keyed_value_extractor.sv
// keyed_value_extractor: top level of the streaming keyed value extractor.
// Depends on kve_pkg, kve_stream_if, kve_cfg_regs, kve_core, kve_result_queue.
`timescale 1ns / 1ps

// Text bytes stream in on "text", one beat per cycle, and the block looks for
// the Nth occurrence (register occurrence, from 1) of the key set in the key
// registers; occurrences may overlap. With picky_mode set, the candidate that
// would be the Nth counts only at the start of the text or right after LF, CR
// or '|'. The bytes after the key, up to NUL, LF, CR or end_of_text, come out
// on "result" with found = 1 and the final one marked last. No match, a key
// that ends the text, or an empty value gives one beat with has_char = 0,
// found = 0, last = 1. All search state clears after each end_of_text beat;
// registers keep their values. Throughput is one text beat per cycle while the
// result queue has room: the key compare runs across all history lanes in
// parallel in one stage behind the input register, and results go out through
// a 4-deep queue so a stalled consumer does not stop input until that queue is
// nearly full. A text beat is registered at the input and its result beats are
// registered in the queue. Write the registers only while no text is in flight.
module keyed_value_extractor import kve_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  kve_stream_if.sink   cfg,
  kve_stream_if.sink   text,
  kve_stream_if.source result
);

  kve_cfg_t  regs;
  kve_push_t push;
  logic      room;

  kve_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // key history, match count and value phases
  kve_core #(
    .KEY_MAX (KEY_MAX)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .regs (regs),
    .room (room),
    .push (push)
  );

  // decouples the result consumer; a byte can add two beats at once
  kve_result_queue u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule
